// ===== rtl/uer_pkg.sv =====
// Package for the ultrasonic echo ranger: constants, codes and shared types.
package uer_pkg;

  localparam int unsigned CHANNELS = 3;
  localparam int unsigned CH_W = 2;
  localparam int unsigned ECHO_W = 3;
  localparam int unsigned TRIG_W_W = 8;
  localparam int unsigned TIME_W = 20;
  localparam int unsigned SCALE_W = 12;
  localparam int unsigned DIST_W = 22;
  localparam int unsigned PROD_W = TIME_W + SCALE_W;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(128);

  // reset values of the configuration registers
  localparam logic [TRIG_W_W-1:0] TRIGGER_WIDTH_RST = 8'd30;
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 20'd800000;
  localparam logic [SCALE_W-1:0] SCALE_RST = 12'd1140;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_HIGH
  } phase_t;

  typedef struct packed {
    logic [TRIG_W_W-1:0] trigger_width_us;
    logic [TIME_W-1:0]   timeout_us;
    logic [SCALE_W-1:0]  cm_per_us_q16;
    logic                enable;
  } cfg_t;

  typedef struct packed {
    logic [ECHO_W-1:0] trigger_lines;
    logic              result_valid;
    logic [CH_W-1:0]   result_channel;
    logic [DIST_W-1:0] distance_cm_q8;
    logic              timed_out;
  } result_t;

endpackage

// ===== rtl/uer_if.sv =====
// Channel interfaces: tick requests in, ranging results out.
interface uer_in_if;
  logic                          valid;
  logic                          ready;
  logic [uer_pkg::ECHO_W-1:0]    echo_levels;

  modport source (output valid, output echo_levels, input ready);
  modport sink (input valid, input echo_levels, output ready);
endinterface

interface uer_out_if;
  logic                          valid;
  logic                          ready;
  logic [uer_pkg::ECHO_W-1:0]    trigger_lines;
  logic                          result_valid;
  logic [uer_pkg::CH_W-1:0]      result_channel;
  logic [uer_pkg::DIST_W-1:0]    distance_cm_q8;
  logic                          timed_out;

  modport source (output valid, output trigger_lines, output result_valid,
                  output result_channel, output distance_cm_q8, output timed_out,
                  input ready);
  modport sink (input valid, input trigger_lines, input result_valid,
                input result_channel, input distance_cm_q8, input timed_out,
                output ready);
endinterface

// ===== rtl/uer_core.sv =====
// Ranging sequencer: per-tick phase, channel and echo timer update.
module uer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [uer_pkg::ECHO_W-1:0] levels,
  input  uer_pkg::cfg_t              cfg,
  output uer_pkg::result_t           result
);

  uer_pkg::phase_t                 phase, phase_next;
  logic [uer_pkg::CH_W-1:0]        channel, channel_next;
  logic [uer_pkg::TIME_W-1:0]      elapsed, elapsed_next;
  logic                            echo_prev, echo_prev_next;

  logic [uer_pkg::CH_W-1:0]        ch, ch_adv;
  logic                            echo;
  logic [uer_pkg::TRIG_W_W-1:0]    width;
  logic [uer_pkg::TIME_W:0]        elapsed_inc;
  logic [uer_pkg::PROD_W-1:0]      product;
  logic [uer_pkg::PROD_W:0]        rounded;
  logic [uer_pkg::PROD_W-8:0]      scaled;
  logic [uer_pkg::DIST_W-1:0]      distance;
  logic                            done, tmo;
  uer_pkg::phase_t                 ph;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= uer_pkg::PH_IDLE;
      channel <= '0;
      elapsed <= '0;
      echo_prev <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      channel <= channel_next;
      elapsed <= elapsed_next;
      echo_prev <= echo_prev_next;
    end
  end

  // distance: elapsed * scale, round half up from q16 to q8, saturate
  assign product = uer_pkg::PROD_W'(elapsed) * uer_pkg::PROD_W'(cfg.cm_per_us_q16);
  assign rounded = {1'b0, product} + uer_pkg::ROUND_HALF;
  assign scaled  = rounded[uer_pkg::PROD_W:8];
  assign distance = (scaled > (uer_pkg::PROD_W-7)'(uer_pkg::DIST_MAX))
                    ? uer_pkg::DIST_MAX : scaled[uer_pkg::DIST_W-1:0];

  always_comb begin
    ch = (channel >= uer_pkg::CH_W'(uer_pkg::CHANNELS)) ? '0 : channel;
    echo = levels[ch];
    width = (cfg.trigger_width_us == '0) ? uer_pkg::TRIG_W_W'(1) : cfg.trigger_width_us;
    ch_adv = (ch == uer_pkg::CH_W'(uer_pkg::CHANNELS - 1)) ? '0 : ch + 1'b1;

    ph = phase;
    elapsed_next = elapsed;
    if (phase == uer_pkg::PH_IDLE && cfg.enable) begin
      ph = uer_pkg::PH_TRIG;
      elapsed_next = '0;
    end
    elapsed_inc = {1'b0, elapsed_next} + 1'b1;

    phase_next = ph;
    done = 1'b0;
    tmo = 1'b0;
    result = '0;

    case (ph)
      uer_pkg::PH_TRIG: begin
        result.trigger_lines = uer_pkg::ECHO_W'(1) << ch;
        if (elapsed_inc >= (uer_pkg::TIME_W+1)'(width)) begin
          phase_next = uer_pkg::PH_WAIT;
          elapsed_next = '0;
        end else begin
          elapsed_next = elapsed_inc[uer_pkg::TIME_W-1:0];
        end
      end
      uer_pkg::PH_WAIT: begin
        if (echo && !echo_prev) begin
          phase_next = uer_pkg::PH_HIGH;
          elapsed_next = uer_pkg::TIME_W'(1);
        end else begin
          elapsed_next = elapsed_inc[uer_pkg::TIME_W-1:0];
          if (elapsed_inc >= {1'b0, cfg.timeout_us}) begin
            done = 1'b1;
            tmo = 1'b1;
          end
        end
      end
      uer_pkg::PH_HIGH: begin
        if (!echo) begin
          done = 1'b1;
          result.distance_cm_q8 = distance;
        end else begin
          elapsed_next = elapsed_inc[uer_pkg::TIME_W-1:0];
          if (elapsed_inc >= {1'b0, cfg.timeout_us}) begin
            done = 1'b1;
            tmo = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    channel_next = ch;
    echo_prev_next = echo;
    result.result_valid = done;
    result.timed_out = tmo;
    if (done) begin
      result.result_channel = ch;
      phase_next = uer_pkg::PH_IDLE;
      elapsed_next = '0;
      channel_next = ch_adv;
      // reload so a pin already high on the next channel is not an edge
      echo_prev_next = levels[ch_adv];
    end
  end

endmodule

// ===== rtl/ultrasonic_echo_ranger.sv =====
// Top level of the three-channel ultrasonic echo ranger.
// Each request is one microsecond tick carrying the sampled echo pins and gives
// exactly one result item: the trigger line levels for that tick and, when a
// measurement ends, the channel, the distance in cm (8 fraction bits, rounded,
// saturated) or a timeout flag. One request is taken every cycle while the
// result register is free or being read; a result passes the input register,
// then the result register, and the sequencer state advances once per request.
// Configuration writes take effect on the next cycle and are meant to be made while the block is idle.
module ultrasonic_echo_ranger (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
  uer_in_if.sink                         samples,
  uer_out_if.source                      results
);

  uer_pkg::cfg_t                 cfg;
  logic                          s1_valid;
  logic [uer_pkg::ECHO_W-1:0]    s1_levels;
  logic                          o_valid;
  uer_pkg::result_t              o_result;
  uer_pkg::result_t              core_result;
  logic                          out_free;
  logic                          step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_width_us <= uer_pkg::TRIGGER_WIDTH_RST;
      cfg.timeout_us <= uer_pkg::TIMEOUT_RST;
      cfg.cm_per_us_q16 <= uer_pkg::SCALE_RST;
      cfg.enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        uer_pkg::REG_TRIGGER_WIDTH: cfg.trigger_width_us <= cfg_data[uer_pkg::TRIG_W_W-1:0];
        uer_pkg::REG_TIMEOUT:       cfg.timeout_us <= cfg_data[uer_pkg::TIME_W-1:0];
        uer_pkg::REG_SCALE:         cfg.cm_per_us_q16 <= cfg_data[uer_pkg::SCALE_W-1:0];
        uer_pkg::REG_ENABLE:        cfg.enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign out_free = !o_valid || results.ready;
  assign step = s1_valid && out_free;
  assign samples.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready && samples.valid) begin
      s1_levels <= samples.echo_levels;
    end
  end

  uer_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .levels (s1_levels),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_result <= core_result;
    end
  end

  assign results.valid = o_valid;
  assign results.trigger_lines = o_result.trigger_lines;
  assign results.result_valid = o_result.result_valid;
  assign results.result_channel = o_result.result_channel;
  assign results.distance_cm_q8 = o_result.distance_cm_q8;
  assign results.timed_out = o_result.timed_out;

endmodule
